// ===== rtl/mecanum_wheel_mixer_macros.svh =====
// assertion macros shared by the mecanum mixer rtl
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

// same-cycle implication, quiet during reset
`define MWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mwm assertion failed");

// next-cycle implication, quiet during reset
`define MWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mwm assertion failed");

`endif

// ===== rtl/mwm_pkg.sv =====
// constants, types and the axis mapping of the mecanum mixer
`default_nettype none

package mwm_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned AxisW     = 11;
  localparam int unsigned MapW      = 9;
  localparam int unsigned MixW      = 11;
  localparam int unsigned MagW      = 10;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned NumW      = MagW + DutyW;
  localparam int unsigned ProdW     = 19;

  // wheel order of the lanes
  localparam int unsigned WheelFl = 0;
  localparam int unsigned WheelFr = 1;
  localparam int unsigned WheelBl = 2;
  localparam int unsigned WheelBr = 3;

  localparam logic signed [AxisW-1:0] AxisMin = -11'sd511;
  localparam logic signed [AxisW-1:0] AxisMax = 11'sd512;
  localparam logic [MagW-1:0]         AxisTop = 10'd1023;
  localparam logic [ProdW-1:0]        MapGain = 19'd510;
  localparam logic [MagW:0]           MapDiv  = 11'd1023;
  localparam logic [MagW-1:0]         DutyMax = 10'd255;

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic signed [MapW-1:0]  map_t;
  typedef logic signed [MixW-1:0]  mix_t;
  typedef logic [MagW-1:0]         mag_t;
  typedef logic [DutyW-1:0]        duty_t;

  // one wheel in the divider chain: remainder, numerator bits shifting
  // out at the top while quotient bits shift in at the bottom
  typedef struct packed {
    logic  neg;
    mag_t  rem;
    duty_t nq;
  } lane_t;

  typedef struct packed {
    mag_t                    div;
    lane_t [NumWheels-1:0]   lane;
  } div_word_t;

  // clamp, then ((a + 511) * 510) / 1023 - 255 with a truncated quotient;
  // y / 1023 is taken as y >> 10 plus one when the remainder reaches 1023
  function automatic map_t map_axis(input axis_t a);
    logic [MagW-1:0]  x;
    logic [ProdW-1:0] y;
    logic [MapW-1:0]  q0;
    logic [MagW:0]    r;
    logic [MapW-1:0]  q;
    logic signed [MapW:0] d;
    if (a < AxisMin) begin
      x = '0;
    end else if (a > AxisMax) begin
      x = AxisTop;
    end else begin
      x = MagW'(a - AxisMin);
    end
    y  = ProdW'(x) * MapGain;
    q0 = y[ProdW-1:MagW];
    r  = (MagW+1)'(y[MagW-1:0]) + (MagW+1)'(q0);
    q  = q0 + MapW'(r >= MapDiv);
    d  = signed'({1'b0, q}) - signed'({1'b0, DutyMax[MapW-1:0]});
    return d[MapW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mwm_if.sv =====
// valid/ready channels for the axis input and the duty output
`default_nettype none

interface mwm_axes_if import mwm_pkg::*;;
  logic  valid;
  logic  ready;
  axis_t axis_strafe;
  axis_t axis_forward;
  axis_t axis_rotate;

  modport source (output valid, output axis_strafe, output axis_forward,
                  output axis_rotate, input ready);
  modport sink (input valid, input axis_strafe, input axis_forward,
                input axis_rotate, output ready);
endinterface

interface mwm_duty_if import mwm_pkg::*;;
  logic  valid;
  logic  ready;
  duty_t front_left_fwd_duty;
  duty_t front_left_rev_duty;
  duty_t front_right_fwd_duty;
  duty_t front_right_rev_duty;
  duty_t back_left_fwd_duty;
  duty_t back_left_rev_duty;
  duty_t back_right_fwd_duty;
  duty_t back_right_rev_duty;

  modport source (output valid, output front_left_fwd_duty, output front_left_rev_duty,
                  output front_right_fwd_duty, output front_right_rev_duty,
                  output back_left_fwd_duty, output back_left_rev_duty,
                  output back_right_fwd_duty, output back_right_rev_duty,
                  input ready);
  modport sink (input valid, input front_left_fwd_duty, input front_left_rev_duty,
                input front_right_fwd_duty, input front_right_rev_duty,
                input back_left_fwd_duty, input back_left_rev_duty,
                input back_right_fwd_duty, input back_right_rev_duty,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/mwm_front.sv =====
// front pipeline: axis mapping, wheel mix, peak search, divider set-up
`default_nettype none

module mwm_front import mwm_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  mwm_axes_if.sink    axes_i,
  output logic        valid_o,
  input  wire         ready_i,
  output div_word_t   word_o
);

  // stage a: mapped axes
  logic a_v_q;
  map_t s_q, f_q, r_q;
  // stage b: mixed wheel speeds
  logic b_v_q;
  mix_t [NumWheels-1:0] w_q;
  // stage c: magnitudes, signs, peak
  logic c_v_q;
  mag_t [NumWheels-1:0] mag_q;
  logic [NumWheels-1:0] neg_q;
  mag_t peak_q;
  // stage d: divider word
  logic d_v_q;
  div_word_t word_q;

  logic a_rdy, b_rdy, c_rdy, d_rdy;

  assign d_rdy = !d_v_q || ready_i;
  assign c_rdy = !c_v_q || d_rdy;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign axes_i.ready = a_rdy;

  mix_t [NumWheels-1:0] w_d;
  mag_t [NumWheels-1:0] mag_d;
  logic [NumWheels-1:0] neg_d;
  mag_t pk01, pk23, peak_d;
  div_word_t word_d;

  always_comb begin
    w_d[WheelFl] = MixW'(f_q) + MixW'(s_q) + MixW'(r_q);
    w_d[WheelFr] = MixW'(f_q) - MixW'(s_q) - MixW'(r_q);
    w_d[WheelBl] = MixW'(f_q) - MixW'(s_q) + MixW'(r_q);
    w_d[WheelBr] = MixW'(f_q) + MixW'(s_q) - MixW'(r_q);
  end

  always_comb begin
    mix_t neg_w;
    for (int i = 0; i < NumWheels; i++) begin
      neg_w    = -w_q[i];
      neg_d[i] = w_q[i][MixW-1];
      mag_d[i] = neg_d[i] ? neg_w[MagW-1:0] : w_q[i][MagW-1:0];
    end
    pk01   = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
    pk23   = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
    peak_d = (pk01 > pk23) ? pk01 : pk23;
  end

  // no scaling is a divide by 255 of speed * 255, which is exact
  always_comb begin
    logic [NumW-1:0] num;
    word_d.div = (peak_q > DutyMax) ? peak_q : DutyMax;
    for (int i = 0; i < NumWheels; i++) begin
      num = {mag_q[i], {DutyW{1'b0}}} - NumW'(mag_q[i]);
      word_d.lane[i].neg = neg_q[i];
      word_d.lane[i].rem = num[NumW-1:DutyW];
      word_d.lane[i].nq  = num[DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= axes_i.valid;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (d_rdy) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && axes_i.valid) begin
      s_q <= map_axis(axes_i.axis_strafe);
      f_q <= map_axis(axes_i.axis_forward);
      r_q <= map_axis(axes_i.axis_rotate);
    end
    if (b_rdy && a_v_q) begin
      w_q <= w_d;
    end
    if (c_rdy && b_v_q) begin
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      peak_q <= peak_d;
    end
    if (d_rdy && c_v_q) begin
      word_q <= word_d;
    end
  end

  assign valid_o = d_v_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ===== rtl/mwm_div_cell.sv =====
// one restoring divide step for all four wheels, registered
`default_nettype none

`include "mecanum_wheel_mixer_macros.svh"

module mwm_div_cell import mwm_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         valid_i,
  output logic        ready_o,
  input  div_word_t   word_i,
  output logic        valid_o,
  input  wire         ready_i,
  output div_word_t   word_o
);

  logic      v_q;
  div_word_t word_q, word_d;
  logic      rem_ok;

  assign ready_o = !v_q || ready_i;

  // bring down the next numerator bit, subtract if it fits
  always_comb begin
    logic [MagW:0] t;
    logic          ge;
    word_d.div = word_i.div;
    for (int i = 0; i < NumWheels; i++) begin
      t  = {word_i.lane[i].rem, word_i.lane[i].nq[DutyW-1]};
      ge = t >= (MagW+1)'(word_i.div);
      word_d.lane[i].neg = word_i.lane[i].neg;
      word_d.lane[i].rem = ge ? MagW'(t - (MagW+1)'(word_i.div)) : t[MagW-1:0];
      word_d.lane[i].nq  = {word_i.lane[i].nq[DutyW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = v_q;
  assign word_o  = word_q;

  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < NumWheels; i++) begin
      if (word_q.lane[i].rem >= word_q.div) rem_ok = 1'b0;
    end
  end

  `MWM_ASSERT_IMP(a_rem_below_div, clk_i, rst_ni, v_q, rem_ok)
  `MWM_ASSERT_IMP(a_div_floor, clk_i, rst_ni, v_q, word_q.div >= DutyMax)

endmodule

`default_nettype wire

// ===== rtl/mecanum_wheel_mixer.sv =====
// top level of the four-wheel mecanum mixer
`default_nettype none

`include "mecanum_wheel_mixer_macros.svh"

// four-wheel mecanum mixer. each transfer on axes_i carries strafe, forward
// and rotate axes; each is clamped to -511..512 and mapped onto -255..255,
// then mixed into four wheel speeds (fl = f+s+r, fr = f-s-r, bl = f-s+r,
// br = f+s-r). if any speed magnitude passes 255 every speed is rescaled to
// speed*255/peak, truncated towards zero. each wheel leaves as a forward and
// a reverse h-bridge duty, the idle side zero. one result transfer on
// duties_o per input transfer, in order. the datapath is a pipeline of
// twelve registered stages: four front stages (map, mix, peak, divider
// set-up) and a chain of eight divide cells that each resolve one quotient
// bit for all four wheels. a new item is taken every cycle while duties_o
// is ready, so the sustained rate is one item per cycle. a stall on
// duties_o reaches back through every full stage in the same cycle over
// the ready chain, empty stages still fill, and the last cell's register
// holds the result while it waits.
module mecanum_wheel_mixer import mwm_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  mwm_axes_if.sink    axes_i,
  mwm_duty_if.source  duties_o
);

  // handshake and data between the front and the first cell and along the cell chain
  logic      valid_c [DutyW+1];
  logic      ready_c [DutyW+1];
  div_word_t word_c  [DutyW+1];

  mwm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .axes_i  (axes_i),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .word_o  (word_c[0])
  );

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < DutyW; k++) begin : g_cell
    mwm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .word_i  (word_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .word_o  (word_c[k+1])
    );
  end

  assign ready_c[DutyW] = duties_o.ready;
  assign duties_o.valid = valid_c[DutyW];

  // split each quotient by sign into forward and reverse duty
  duty_t [NumWheels-1:0] fwd, rev;
  logic                  one_side_ok;

  always_comb begin
    one_side_ok = 1'b1;
    for (int i = 0; i < NumWheels; i++) begin
      fwd[i] = word_c[DutyW].lane[i].neg ? '0 : word_c[DutyW].lane[i].nq;
      rev[i] = word_c[DutyW].lane[i].neg ? word_c[DutyW].lane[i].nq : '0;
      if ((fwd[i] != '0) && (rev[i] != '0)) one_side_ok = 1'b0;
    end
  end

  assign duties_o.front_left_fwd_duty  = fwd[WheelFl];
  assign duties_o.front_left_rev_duty  = rev[WheelFl];
  assign duties_o.front_right_fwd_duty = fwd[WheelFr];
  assign duties_o.front_right_rev_duty = rev[WheelFr];
  assign duties_o.back_left_fwd_duty   = fwd[WheelBl];
  assign duties_o.back_left_rev_duty   = rev[WheelBl];
  assign duties_o.back_right_fwd_duty  = fwd[WheelBr];
  assign duties_o.back_right_rev_duty  = rev[WheelBr];

  // a wheel never drives both bridge sides at once
  `MWM_ASSERT_IMP(a_one_side, clk_i, rst_ni, duties_o.valid, one_side_ok)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the four-wheel mecanum mixer
`timescale 1ns / 1ps

module testbench;
  import mwm_pkg::*;

  // the eight duties of one result transfer, in port order
  typedef struct packed {
    duty_t fl_fwd;
    duty_t fl_rev;
    duty_t fr_fwd;
    duty_t fr_rev;
    duty_t bl_fwd;
    duty_t bl_rev;
    duty_t br_fwd;
    duty_t br_rev;
  } wheel_duties_t;

  // one row of the directed table; typed rows carry a hand-worked result
  typedef struct packed {
    axis_t         strafe;
    axis_t         forward;
    axis_t         rotate;
    logic          typed;
    wheel_duties_t duties;
  } stick_row_t;

  localparam int RandomSticks = 400;
  localparam int DrainCycles  = 40;

  logic clk_i;
  logic rst_ni;

  mwm_axes_if axes_ch ();
  mwm_duty_if duties_ch ();

  mecanum_wheel_mixer uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .axes_i   (axes_ch),
    .duties_o (duties_ch)
  );

  wheel_duties_t pending_duties[$];
  stick_row_t    stick_table[$];
  int            mismatch_count = 0;
  logic          no_idling = 1'b0;

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // generous ceiling: the slowest legal run is well under a quarter of this
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // clamp to -511..512, then rescale onto -255..255 with a truncated quotient
  function automatic int scale_stick(input axis_t raw);
    int v;
    int lo;
    int hi;
    int top;
    lo  = int'(AxisMin);
    hi  = int'(AxisMax);
    top = int'(DutyMax);
    v   = int'(raw);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return ((v - lo) * (2 * top)) / (hi - lo) - top;
  endfunction

  // mix into four wheels, bring the peak back to full scale, split per bridge
  function automatic wheel_duties_t mix_duties(input axis_t strafe, input axis_t forward,
                                               input axis_t rotate);
    int s;
    int f;
    int r;
    int top;
    int peak;
    int w[4];
    duty_t fwd[4];
    duty_t rev[4];
    wheel_duties_t res;
    s    = scale_stick(strafe);
    f    = scale_stick(forward);
    r    = scale_stick(rotate);
    top  = int'(DutyMax);
    w[WheelFl] = f + s + r;
    w[WheelFr] = f - s - r;
    w[WheelBl] = f - s + r;
    w[WheelBr] = f + s - r;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      if ((w[i] < 0 ? -w[i] : w[i]) > peak) peak = (w[i] < 0 ? -w[i] : w[i]);
    end
    // signed int division truncates towards zero, as the block does
    if (peak > top) begin
      for (int i = 0; i < 4; i++) w[i] = (w[i] * top) / peak;
    end
    for (int i = 0; i < 4; i++) begin
      if (w[i] >= 0) begin
        fwd[i] = duty_t'(w[i]);
        rev[i] = '0;
      end else begin
        fwd[i] = '0;
        rev[i] = duty_t'(-w[i]);
      end
    end
    res.fl_fwd = fwd[WheelFl];
    res.fl_rev = rev[WheelFl];
    res.fr_fwd = fwd[WheelFr];
    res.fr_rev = rev[WheelFr];
    res.bl_fwd = fwd[WheelBl];
    res.bl_rev = rev[WheelBl];
    res.br_fwd = fwd[WheelBr];
    res.br_rev = rev[WheelBr];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (no_idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // in-range sticks mostly, some end stops, some raw 11-bit noise
  function automatic axis_t pick_stick();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        return axis_t'($urandom_range(0, 2047));
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       return AxisMin;
          1:       return AxisMax;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        return axis_t'(int'($urandom_range(0, 1023)) - 511);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------

  task automatic add_row(input int s, input int f, input int r);
    stick_row_t row;
    row.strafe  = axis_t'(s);
    row.forward = axis_t'(f);
    row.rotate  = axis_t'(r);
    row.typed   = 1'b0;
    row.duties  = '0;
    stick_table.push_back(row);
  endtask

  task automatic add_typed_row(input int s, input int f, input int r,
                               input wheel_duties_t duties);
    stick_row_t row;
    row.strafe  = axis_t'(s);
    row.forward = axis_t'(f);
    row.rotate  = axis_t'(r);
    row.typed   = 1'b1;
    row.duties  = duties;
    stick_table.push_back(row);
  endtask

  // one input transfer; called just after the previous transfer's edge, so
  // valid only ever sees one assignment per time step
  task automatic send_sticks(input stick_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      axes_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    axes_ch.valid        <= 1'b1;
    axes_ch.axis_strafe  <= row.strafe;
    axes_ch.axis_forward <= row.forward;
    axes_ch.axis_rotate  <= row.rotate;
    @(posedge clk_i);
    while (!axes_ch.ready) @(posedge clk_i);
    // transfer taken at this edge
    if (row.typed) begin
      pending_duties.push_back(row.duties);
    end else begin
      pending_duties.push_back(mix_duties(row.strafe, row.forward, row.rotate));
    end
  endtask

  initial begin
    stick_row_t row;
    int         wait_cycles;

    axes_ch.valid        <= 1'b0;
    axes_ch.axis_strafe  <= '0;
    axes_ch.axis_forward <= '0;
    axes_ch.axis_rotate  <= '0;
    rst_ni               <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full deflection on every stick: fl peaks at 765, the rest land on 85
    add_typed_row(512, 512, 512, '{8'd255, 8'd0, 8'd0, 8'd85, 8'd85, 8'd0, 8'd85, 8'd0});
    add_typed_row(-511, -511, -511,
                  '{8'd0, 8'd255, 8'd85, 8'd0, 8'd0, 8'd85, 8'd0, 8'd85});
    // sticks at rest read as -1 each, so no wheel sits still
    add_typed_row(0, 0, 0, '{8'd0, 8'd3, 8'd1, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1});
    // beyond the end stops: clamped onto the full-deflection results
    add_typed_row(1023, 1023, 1023,
                  '{8'd255, 8'd0, 8'd0, 8'd85, 8'd85, 8'd0, 8'd85, 8'd0});
    add_typed_row(-1024, -1024, -1024,
                  '{8'd0, 8'd255, 8'd85, 8'd0, 8'd0, 8'd85, 8'd0, 8'd85});
    // one stick at a time, each end
    add_row(512, 0, 0);
    add_row(-511, 0, 0);
    add_row(0, 512, 0);
    add_row(0, -511, 0);
    add_row(0, 0, 512);
    add_row(0, 0, -511);
    // just past the end stops and mixed out-of-range patterns
    add_row(513, -512, 0);
    add_row(-512, 513, 1023);
    add_row(1023, -1024, -1);
    add_row(1, -1, 0);
    // small demands that stay under full scale and pass unscaled
    add_row(0, 200, 0);
    add_row(100, -100, 50);
    add_row(-1, -1, -1);
    // larger mixes that need the rescale
    add_row(-300, 300, -300);
    add_row(341, -341, 0);

    foreach (stick_table[i]) send_sticks(stick_table[i]);

    // random part, with a stretch of flat-out traffic every third phase
    for (int i = 0; i < RandomSticks; i++) begin
      no_idling   = ((i / 60) % 3) == 2;
      row.strafe  = pick_stick();
      row.forward = pick_stick();
      row.rotate  = pick_stick();
      row.typed   = 1'b0;
      row.duties  = '0;
      send_sticks(row);
    end
    axes_ch.valid <= 1'b0;
    no_idling     = 1'b0;

    // drain, then wait out a quiet stretch to catch stray results
    while (pending_duties.size() != 0) @(posedge clk_i);
    wait_cycles = DrainCycles;
    repeat (wait_cycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_duties.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------

  // back-pressure on the duty channel, same gap profile as the sender
  initial begin
    int stall;
    duties_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        duties_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      duties_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic check_duty(input string name, input duty_t want, input duty_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // every result transfer is matched against the oldest outstanding one
  always @(posedge clk_i) begin
    wheel_duties_t want;
    if (rst_ni && duties_ch.valid && duties_ch.ready) begin
      if (pending_duties.size() == 0) begin
        $error("result transfer with no input outstanding");
        mismatch_count++;
      end else begin
        want = pending_duties.pop_front();
        check_duty("front_left_fwd_duty", want.fl_fwd, duties_ch.front_left_fwd_duty);
        check_duty("front_left_rev_duty", want.fl_rev, duties_ch.front_left_rev_duty);
        check_duty("front_right_fwd_duty", want.fr_fwd, duties_ch.front_right_fwd_duty);
        check_duty("front_right_rev_duty", want.fr_rev, duties_ch.front_right_rev_duty);
        check_duty("back_left_fwd_duty", want.bl_fwd, duties_ch.back_left_fwd_duty);
        check_duty("back_left_rev_duty", want.bl_rev, duties_ch.back_left_rev_duty);
        check_duty("back_right_fwd_duty", want.br_fwd, duties_ch.back_right_fwd_duty);
        check_duty("back_right_rev_duty", want.br_rev, duties_ch.back_right_rev_duty);
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mwm_pkg.sv
rtl/mwm_if.sv
rtl/mwm_front.sv
rtl/mwm_div_cell.sv
rtl/mecanum_wheel_mixer.sv
dv/testbench.sv
